// File: hw/rtl/gcg_pkg.sv
package gcg_pkg;

    localparam int CORDIC_ITERATIONS = 20;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int CW                = 34;
    localparam int SQRT_STEPS        = 31;

    localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;

    localparam logic [24:0] PI_DIV45  = 25'd18740330;
    localparam logic [24:0] RECIP15   = 25'd17895698;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [34:0]   PI_Q30   = 35'sd3373259426;
    localparam logic signed [32:0]   ONE_Q30  = 33'sd1073741824;
    localparam logic [20:0]          RADIUS_SCALE = 21'd1630976;
    localparam logic [22:0]          DIST_MAX = 23'd5123864;

    typedef struct packed {
        logic                 vld;
        logic                 neg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic        vld;
        logic        neg;
        logic [30:0] a;
        logic [60:0] rem;
        logic [30:0] root;
    } t_sqrt;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'h3243F6A8;
            5'd1:    r = 30'h1DAC6705;
            5'd2:    r = 30'h0FADBAFC;
            5'd3:    r = 30'h07F56EA6;
            5'd4:    r = 30'h03FEAB76;
            5'd5:    r = 30'h01FFD55B;
            5'd6:    r = 30'h00FFFAAA;
            5'd7:    r = 30'h007FFF55;
            5'd8:    r = 30'h003FFFEA;
            5'd9:    r = 30'h001FFFFD;
            5'd10:   r = 30'h000FFFFF;
            5'd11:   r = 30'h0007FFFF;
            5'd12:   r = 30'h0003FFFF;
            5'd13:   r = 30'h0001FFFF;
            5'd14:   r = 30'h0000FFFF;
            5'd15:   r = 30'h00007FFF;
            5'd16:   r = 30'h00003FFF;
            5'd17:   r = 30'h00001FFF;
            5'd18:   r = 30'h00000FFF;
            5'd19:   r = 30'h000007FF;
            5'd20:   r = 30'h000003FF;
            5'd21:   r = 30'h000001FF;
            5'd22:   r = 30'h000000FF;
            5'd23:   r = 30'h0000007F;
            5'd24:   r = 30'h0000003F;
            5'd25:   r = 30'h0000001F;
            5'd26:   r = 30'h0000000F;
            5'd27:   r = 30'h00000008;
            5'd28:   r = 30'h00000004;
            5'd29:   r = 30'h00000002;
            5'd30:   r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/gcg_cordic_cell.sv
module gcg_cordic_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vec,
    input  logic [4:0]       i_idx,
    input  gcg_pkg::t_cordic i_d,
    output gcg_pkg::t_cordic o_q
);
    import gcg_pkg::*;

    logic signed [CW-1:0] dx, dy, da;
    logic                 ccw;
    t_cordic              n_q;
    t_cordic              r_q;
    logic                 r_vld;

    assign dx  = i_d.y >>> i_idx;
    assign dy  = i_d.x >>> i_idx;
    assign da  = {{(CW-30){1'b0}}, atan_q30(i_idx)};
    assign ccw = i_vec ? (i_d.y < 0) : (i_d.z >= 0);

    always_comb begin
        n_q     = i_d;
        if (ccw) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - da;
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    always_comb begin
        o_q     = r_q;
        o_q.vld = r_vld;
    end

endmodule

// File: hw/rtl/gcg_sqrt_cell.sv
module gcg_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [4:0]     i_bit,
    input  gcg_pkg::t_sqrt i_d,
    output gcg_pkg::t_sqrt o_q
);
    import gcg_pkg::*;

    logic [61:0] trial;
    logic        take;
    t_sqrt       n_q;
    t_sqrt       r_q;
    logic        r_vld;

    assign trial = ({31'd0, i_d.root} << (6'(i_bit) + 6'd1)) + (62'd1 << {i_bit, 1'b0});
    assign take  = {1'b0, i_d.rem} >= trial;

    always_comb begin
        n_q = i_d;
        if (take) begin
            n_q.rem  = i_d.rem - trial[60:0];
            n_q.root = i_d.root | (31'd1 << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    always_comb begin
        o_q     = r_q;
        o_q.vld = r_vld;
    end

endmodule

// File: hw/rtl/gcg_angle_prep.sv
module gcg_angle_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [26:0] i_ang,
    output gcg_pkg::t_cordic   o_q
);
    import gcg_pkg::*;

    logic [5:0]         r_vld;
    logic signed [24:0] r1_a;
    logic signed [23:0] r2_a;
    logic               r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic [22:0]        r3_mag;
    logic               r3_sgn, r4_sgn, r5_sgn;
    logic [47:0]        r4_pa;
    logic [48:0]        r4_p15;
    logic [30:0]        r5_t;
    logic signed [CW-1:0] r6_z;

    logic signed [26:0] n1_a, w2_a;
    logic signed [26:0] n2_a;
    logic               n2_neg;
    logic [47:0]        w5_sum;

    always_comb begin
        if (i_ang >= HALF_TURN) begin
            n1_a = i_ang - FULL_TURN;
        end else if (i_ang < -HALF_TURN) begin
            n1_a = i_ang + FULL_TURN;
        end else begin
            n1_a = i_ang;
        end
    end

    assign w2_a = 27'(r1_a);

    always_comb begin
        n2_a   = w2_a;
        n2_neg = 1'b0;
        if (w2_a > QUARTER_TURN) begin
            n2_a   = HALF_TURN - w2_a;
            n2_neg = 1'b1;
        end else if (w2_a < -QUARTER_TURN) begin
            n2_a   = -HALF_TURN - w2_a;
            n2_neg = 1'b1;
        end
    end

    assign w5_sum = r4_pa + 48'd32768 + {27'd0, r4_p15[48:28]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= n1_a[24:0];
            r2_a   <= n2_a[23:0];
            r2_neg <= n2_neg;
            r3_mag <= r2_a[23] ? 23'(-r2_a) : r2_a[22:0];
            r3_sgn <= r2_a[23];
            r3_neg <= r2_neg;
            r4_pa  <= r3_mag * PI_DIV45;
            r4_p15 <= {r3_mag, 1'b0} * RECIP15;
            r4_sgn <= r3_sgn;
            r4_neg <= r3_neg;
            r5_t   <= w5_sum[46:16];
            r5_sgn <= r4_sgn;
            r5_neg <= r4_neg;
            r6_z   <= r5_sgn ? -CW'(r5_t) : CW'(r5_t);
            r6_neg <= r5_neg;
        end
    end

    always_comb begin
        o_q.vld = r_vld[5];
        o_q.neg = r6_neg;
        o_q.x   = GAIN_Q30;
        o_q.y   = '0;
        o_q.z   = r6_z;
    end

endmodule

// File: hw/rtl/great_circle_geofence_top.sv
// channel   | direction | handshake                    | content
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | two positions
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | distance, inside flag
// cfg       | in        | i_cfg_valid/o_cfg_ready      | fence radius
// one position pair per cycle while the output is not stalled; the data passes through the
// rotation cells, the 31-cell root chain and the vectoring cells
// synchronous active-low reset clears all valid bits and the fence radius
// a result held at the output with m_axis_tready low freezes the whole pipeline
// and drops s_axis_tready; the fence register is always ready
module great_circle_geofence_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_latitude, center_longitude, other_latitude, other_longitude, zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance, zero pad
    output logic [23:0]  m_axis_tdata,
    // inside_res
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [22:0]  i_cfg_data
);
    import gcg_pkg::*;

    logic en;
    logic [22:0] r_fence;

    logic               r0_vld;
    logic signed [26:0] r0_lat1, r0_lat2, r0_dlon;
    logic signed [23:0] in_lat1, in_lat2;
    logic signed [24:0] in_lon1, in_lon2;

    t_cordic w_rot [0:2][0:CORDIC_STEPS];
    t_sqrt   w_sq  [0:SQRT_STEPS];
    t_cordic w_vec [0:CORDIC_STEPS];

    logic [6:0]         r_pv;
    logic signed [31:0] r_s1, r_s2, r_c1, r_c2, r_cd, r1_cd;
    logic signed [63:0] r_pss, r_pcc, r_pccd;
    logic signed [31:0] r_ss, w_cc;
    logic signed [32:0] w_sum;
    logic signed [31:0] r_sum;
    logic               r_sum_vld;
    logic [30:0]        r_a, r5_a, r6_a;
    logic               r_an, r5_an, r6_an;
    logic [60:0]        r_aa, r_v;
    logic signed [34:0] w_ang;
    logic [32:0]        r_ang;
    logic [53:0]        r_prod;
    logic [24:0]        w_dist;
    logic [22:0]        w_dist_sat;
    logic               r_out_vld;
    logic [22:0]        r_dist;
    logic               r_inside;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fence <= '0;
        end else if (i_cfg_valid) begin
            r_fence <= i_cfg_data;
        end
    end

    assign in_lat1 = s_axis_tdata[23:0];
    assign in_lon1 = s_axis_tdata[48:24];
    assign in_lat2 = s_axis_tdata[72:49];
    assign in_lon2 = s_axis_tdata[97:73];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_lat1 <= 27'(in_lat1);
            r0_lat2 <= 27'(in_lat2);
            r0_dlon <= 27'(in_lon1) - 27'(in_lon2);
        end
    end

    gcg_angle_prep u_prep_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_ang(r0_lat1), .o_q(w_rot[0][0])
    );
    gcg_angle_prep u_prep_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_ang(r0_lat2), .o_q(w_rot[1][0])
    );
    gcg_angle_prep u_prep_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r0_vld),
        .i_ang(r0_dlon), .o_q(w_rot[2][0])
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
            gcg_cordic_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vec(1'b0),
                .i_idx(5'(g)), .i_d(w_rot[l][g]), .o_q(w_rot[l][g+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_sum_vld <= 1'b0;
        end else if (en) begin
            r_pv      <= {r_pv[5:0], w_rot[0][CORDIC_STEPS].vld};
            r_sum_vld <= r_pv[2];
        end
    end

    assign w_cc  = 32'(r_pcc >>> 30);
    assign w_sum = 33'(r_ss) + 33'(r_pccd >>> 30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1   <= 32'(w_rot[0][CORDIC_STEPS].y);
            r_s2   <= 32'(w_rot[1][CORDIC_STEPS].y);
            r_c1   <= w_rot[0][CORDIC_STEPS].neg ? 32'(-w_rot[0][CORDIC_STEPS].x)
                                                 : 32'(w_rot[0][CORDIC_STEPS].x);
            r_c2   <= w_rot[1][CORDIC_STEPS].neg ? 32'(-w_rot[1][CORDIC_STEPS].x)
                                                 : 32'(w_rot[1][CORDIC_STEPS].x);
            r_cd   <= w_rot[2][CORDIC_STEPS].neg ? 32'(-w_rot[2][CORDIC_STEPS].x)
                                                 : 32'(w_rot[2][CORDIC_STEPS].x);
            r_pss  <= r_s1 * r_s2;
            r_pcc  <= r_c1 * r_c2;
            r1_cd  <= r_cd;
            r_ss   <= 32'(r_pss >>> 30);
            r_pccd <= w_cc * r1_cd;
            if (w_sum > ONE_Q30) begin
                r_sum <= 32'(ONE_Q30);
            end else if (w_sum < -ONE_Q30) begin
                r_sum <= 32'(-ONE_Q30);
            end else begin
                r_sum <= 32'(w_sum);
            end
            r_a    <= r_sum[31] ? 31'(-r_sum) : r_sum[30:0];
            r_an   <= r_sum[31];
            r_aa   <= r_a * r_a;
            r5_a   <= r_a;
            r5_an  <= r_an;
            r_v    <= {1'b1, 60'd0} - r_aa;
            r6_a   <= r5_a;
            r6_an  <= r5_an;
        end
    end

    always_comb begin
        w_sq[0].vld  = r_pv[6];
        w_sq[0].neg  = r6_an;
        w_sq[0].a    = r6_a;
        w_sq[0].rem  = r_v;
        w_sq[0].root = '0;
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        gcg_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_bit(5'(SQRT_STEPS - 1 - g)), .i_d(w_sq[g]), .o_q(w_sq[g+1])
        );
    end

    always_comb begin
        w_vec[0].vld = w_sq[SQRT_STEPS].vld;
        w_vec[0].neg = w_sq[SQRT_STEPS].neg;
        w_vec[0].x   = CW'(w_sq[SQRT_STEPS].a);
        w_vec[0].y   = CW'(w_sq[SQRT_STEPS].root);
        w_vec[0].z   = '0;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
        gcg_cordic_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vec(1'b1),
            .i_idx(5'(g)), .i_d(w_vec[g]), .o_q(w_vec[g+1])
        );
    end

    logic [1:0] r_vv;

    assign w_ang = w_vec[CORDIC_STEPS].neg ? PI_Q30 - 35'(w_vec[CORDIC_STEPS].z)
                                           : 35'(w_vec[CORDIC_STEPS].z);
    assign w_dist = 25'((r_prod + 54'd536870912) >> 30);
    assign w_dist_sat = (w_dist > 25'(DIST_MAX)) ? DIST_MAX : w_dist[22:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv      <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vv      <= {r_vv[0], w_vec[CORDIC_STEPS].vld};
            r_out_vld <= r_vv[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang    <= w_ang[34] ? 33'd0 : w_ang[32:0];
            r_prod   <= r_ang * RADIUS_SCALE;
            r_dist   <= w_dist_sat;
            r_inside <= w_dist_sat <= r_fence;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_dist};
    assign m_axis_tuser  = r_inside;

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:0] <= DIST_MAX)
        else $error("distance above limit");

    a_sum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_vld |-> (33'(r_sum) <= ONE_Q30 && 33'(r_sum) >= -ONE_Q30))
        else $error("cosine sum not saturated");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

endmodule

// File: bench/great_circle_geofence_top_tb.sv
`timescale 1ns / 1ps

module great_circle_geofence_top_tb;
    import gcg_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS + 47;

    typedef struct {
        logic [22:0] distance;
        logic        inside_res;
    } t_fence_result;

    class t_scoreboard;
        t_fence_result pending[$];
        int            errors;
        int            checked;

        function void note_transfer(t_fence_result r);
            pending.push_back(r);
        endfunction

        function void check_result(logic [22:0] got_dist, logic got_flag);
            t_fence_result e;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result distance=%0d inside_res=%0d", got_dist, got_flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got_dist !== e.distance) begin
                $error("distance expected %0d actual %0d", e.distance, got_dist);
                errors++;
            end
            if (got_flag !== e.inside_res) begin
                $error("inside_res expected %0d actual %0d", e.inside_res, got_flag);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [22:0]  i_cfg_data;

    great_circle_geofence_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    t_scoreboard     sb;
    logic [22:0]     fence_radius;
    int              send_idle_pct;
    int              recv_idle_pct;
    bit              hold_off;
    int              sent_items;

    localparam longint ATAN_TAB[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_units(longint u);
        longint v;
        v = u % 23592960;
        if (v < 0) v += 23592960;
        if (v >= 11796480) v -= 23592960;
        return v;
    endfunction

    task automatic rotate_angle(input longint u, output longint s, output longint c);
        longint a, mag, z, x, y, dx, dy;
        bit     flip;
        a = wrap_units(u);
        flip = 0;
        x = 652032874;
        y = 0;
        if (a > 5898240) begin
            a = 11796480 - a;
            flip = 1;
        end else if (a < -5898240) begin
            a = -11796480 - a;
            flip = 1;
        end
        mag = a < 0 ? -a : a;
        z = (mag * 843314856 + 1474560) / 2949120;
        if (a < 0) z = -z;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint arc_cosine(longint c);
        longint a, x, y, z, dx, dy;
        a = c < 0 ? -c : c;
        x = a;
        z = 0;
        y = int_root((64'd1 << 60) - longint'(a * a));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        if (c < 0) z = 64'sd3373259426 - z;
        return z;
    endfunction

    task automatic predict_distance(input logic [103:0] pkt, output t_fence_result r);
        longint lat1, lon1, lat2, lon2, s1, c1, s2, c2, sd, cd, sum, ang, km_units;
        lat1 = longint'($signed(pkt[23:0]));
        lon1 = longint'($signed(pkt[48:24]));
        lat2 = longint'($signed(pkt[72:49]));
        lon2 = longint'($signed(pkt[97:73]));
        rotate_angle(lat1, s1, c1);
        rotate_angle(lat2, s2, c2);
        rotate_angle(lon1 - lon2, sd, cd);
        sum = floor_shift(s1 * s2, 30) + floor_shift(floor_shift(c1 * c2, 30) * cd, 30);
        if (sum > 1073741824) sum = 1073741824;
        if (sum < -1073741824) sum = -1073741824;
        ang = arc_cosine(sum);
        if (ang < 0) ang = 0;
        km_units = (ang * (6371 * 256) + (64'sd1 << 29)) >>> 30;
        if (km_units > 5123864) km_units = 5123864;
        r.distance = km_units[22:0];
        r.inside_res = (km_units <= longint'(fence_radius));
    endtask

    function automatic logic [103:0] pack_positions(logic [23:0] la1, logic [24:0] lo1,
                                                    logic [23:0] la2, logic [24:0] lo2);
        return {6'd0, lo2, la2, lo1, la1};
    endfunction

    function automatic logic [23:0] rand_lat();
        case ($urandom_range(0, 9))
            0: return 24'(-5898240);
            1: return 24'd5898240;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 11796480)) - 5898240);
        endcase
    endfunction

    function automatic logic [24:0] rand_lon();
        case ($urandom_range(0, 9))
            0: return 25'(-11796480);
            1: return 25'd11796480;
            2: return 25'($urandom);
            default: return 25'($signed($urandom_range(0, 23592960)) - 11796480);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_fence_result r;
            predict_distance(s_axis_tdata, r);
            sb.note_transfer(r);
            sent_items++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[22:0], m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [103:0] pkt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pkt;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [22:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        fence_radius = val;
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
            send_item(pack_positions(rand_lat(), rand_lon(), rand_lat(), rand_lon()));
    endtask

    initial begin
        sb = new();
        fence_radius = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        sent_items = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: poles, antimeridian, same point, antipodes, out-of-range codes
        send_item(pack_positions(24'd0, 25'd0, 24'd0, 25'd0));
        send_item(pack_positions(24'd5898240, 25'd0, 24'(-5898240), 25'd0));
        send_item(pack_positions(24'd0, 25'd11796480, 24'd0, 25'(-11796480)));
        send_item(pack_positions(24'd0, 25'd0, 24'd0, 25'd11796480));
        send_item(pack_positions(24'd1000, 25'd2000, 24'd1000, 25'd2000));
        send_item(pack_positions(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000));
        send_item(pack_positions(24'hFFFFFF, 25'h1FFFFFF, 24'h000001, 25'h0000001));
        send_item(pack_positions(24'd5898240, 25'd3000000, 24'd5898240, 25'(-3000000)));
        send_item(pack_positions(24'd65536, 25'd0, 24'd0, 25'd0));
        send_item(pack_positions(24'(-3000000), 25'd11796480, 24'd3000000, 25'd0));
        send_item(pack_positions(24'd0, 25'd0, 24'd0, 25'd1));
        wait_drained();
        write_radius(23'd5123864);
        send_item(pack_positions(24'd0, 25'd0, 24'd0, 25'd11796480));
        send_item(pack_positions(24'd100, 25'd0, 24'd0, 25'd0));
        wait_drained();
        write_radius(23'h7FFFFF);
        send_item(pack_positions(24'd0, 25'd0, 24'd0, 25'd11796480));
        wait_drained();
        write_radius(23'd256000);

        send_idle_pct = 27;
        recv_idle_pct = 56;
        random_phase(150);
        wait_drained();
        write_radius(23'($urandom_range(0, 5123864)));

        send_idle_pct = 56;
        recv_idle_pct = 27;
        random_phase(150);
        wait_drained();
        write_radius(23'd0);

        // receiver stalls long while the sender keeps pushing
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(120);
        join
        wait_drained();
        write_radius(23'd2561932);
        random_phase(110);
        wait_drained();

        $display("covered %0d position pairs, %0d results checked, several fence radii",
                 sent_items, sb.checked);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
